// ===== rtl/tsvm_pkg.sv =====
// ----------------------------------------------------------------------------
// tsvm_pkg: shared definitions for the triggered sample voice mixer
// Item kinds, register indexes, default sizes and the velocity gain.
// ----------------------------------------------------------------------------
package tsvm_pkg;

  // Default sizes handed to the top level.
  localparam int VOICES_DEF        = 8;
  localparam int TICKS_PER_BAR_DEF = 3840;
  localparam int SAMPLE_DEPTH_DEF  = 65536;

  // Input item kinds.
  localparam logic [2:0] KIND_LOAD  = 3'd0;
  localparam logic [2:0] KIND_LOOP  = 3'd1;
  localparam logic [2:0] KIND_TICK  = 3'd2;
  localparam logic [2:0] KIND_FRAME = 3'd3;
  localparam logic [2:0] KIND_START = 3'd4;
  localparam logic [2:0] KIND_STOP  = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_STEREO = 2'd0;
  localparam logic [1:0] REG_PITCH  = 2'd1;
  localparam logic [1:0] REG_END    = 2'd2;
  localparam logic [1:0] REG_VOLUME = 2'd3;

  // Register reset values.
  localparam logic [17:0] PITCH_RESET  = 18'd65536;
  localparam logic [16:0] END_RESET    = 17'd65536;
  localparam logic [15:0] VOLUME_RESET = 16'd22938;

  // Output range.
  localparam int OUT_W = 20;

  // Q1.15 gain of velocity/127, rounded to nearest.
  // 32768 = 127 * 258 + 2, so the quotient is 258*v plus a remainder term
  // (2*v + 63) / 127 that is at most 2.
  function automatic logic [15:0] velocity_gain(input logic [6:0] vel);
    logic [15:0] base;
    logic [8:0]  rem;
    base = 16'(vel) * 16'd258;
    rem  = {1'b0, vel, 1'b0} + 9'd63;
    if (rem >= 9'd254) begin
      return base + 16'd2;
    end else if (rem >= 9'd127) begin
      return base + 16'd1;
    end
    return base;
  endfunction

endpackage

// ===== rtl/triggered_sample_voice_mixer.sv =====
// ----------------------------------------------------------------------------
// triggered_sample_voice_mixer: drum-style sampler voice engine
// Voices triggered by pulse ticks read one sample memory and are mixed.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item of a given kind:
//   load a sample word, loop start, pulse tick, frame, start or stop.
//   Only a frame gives a result item on the output channel
//   (out_valid / out_stall) with the left and right mix.
//   Load, loop start and stop are done in the idle state. A tick with a hit
//   is wrapped into the bar by one step per TICKS_PER_BAR subtracted.
//   A frame holds in_stall while it walks the voices: a free voice is only
//   checked, a busy voice goes through a read of the position memory, a read
//   of the sample memory and a multiply-accumulate; then come the end of the
//   walk, two steps of volume scaling and the output step.
//   Items are handled one at a time; in_stall is high while one is at work.
//   The result sits in an output register, so the next item is taken while
//   it waits; a frame that finishes while the previous result is still
//   stalled waits in its last step until the register frees up.
//   After reset, and after a start item while stopped, the position memory
//   is cleared one entry per cycle with in_stall high. Configuration writes
//   are taken at any time. SAMPLE_DEPTH must be a power of 2 (unchecked).
// ----------------------------------------------------------------------------
module triggered_sample_voice_mixer #(
  parameter int VOICES        = tsvm_pkg::VOICES_DEF,
  parameter int TICKS_PER_BAR = tsvm_pkg::TICKS_PER_BAR_DEF,
  parameter int SAMPLE_DEPTH  = tsvm_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [1:0]                          cfg_index,
  input  logic [17:0]                         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          kind,
  input  logic [15:0]                         mem_address,
  input  logic signed [15:0]                  mem_value,
  input  logic [11:0]                         tick_index,
  input  logic                                hit,
  input  logic [6:0]                          velocity,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tsvm_pkg::OUT_W-1:0]   left_out,
  output logic signed [tsvm_pkg::OUT_W-1:0]   right_out
);
  import tsvm_pkg::*;

  localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VCW   = $clog2(VOICES + 1);
  localparam int TW    = (TICKS_PER_BAR > 1) ? $clog2(TICKS_PER_BAR) : 1;
  localparam int AW    = $clog2(SAMPLE_DEPTH);
  localparam int SUM_W = 32 + VCW;
  localparam int HI_W  = SUM_W - 16;
  localparam int HP_W  = HI_W + 17;
  localparam int FW    = HP_W + 17;
  localparam int SH_W  = FW - 30;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_TMOD, S_CHECK, S_POS, S_MAC, S_SC1, S_SC2, S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic        stereo;
  logic [17:0] pitch_step;
  logic [16:0] end_position;
  logic [15:0] volume;

  // Control state.
  logic          running;
  logic          armed;
  logic [TW-1:0] clr_cnt;
  logic [11:0]   tick_reg;
  logic [6:0]    vel_reg;
  logic [VCW-1:0] vidx;

  // Voice registers.
  logic          busy  [VOICES];
  logic [TW-1:0] vtick [VOICES];
  logic [6:0]    vvel  [VOICES];

  // Datapath registers.
  logic [15:0]              gain_q;
  logic signed [SUM_W-1:0]  lsum;
  logic signed [SUM_W-1:0]  rsum;
  logic [31:0]              lo_l;
  logic [31:0]              lo_r;
  logic signed [HP_W-1:0]   hi_l;
  logic signed [HP_W-1:0]   hi_r;

  // Memories.
  logic signed [15:0] smem [SAMPLE_DEPTH];
  logic [31:0]        pmem [TICKS_PER_BAR];
  logic signed [15:0] sm_l_q;
  logic signed [15:0] sm_r_q;
  logic [31:0]        pm_q;

  logic [VW-1:0] vsel;
  assign vsel = vidx[VW-1:0];

  assign in_stall = (state != S_IDLE);

  // Lowest free voice.
  logic          free_found;
  logic [VW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_found = 1'b1;
        free_idx   = VW'(i);
      end
    end
  end

  // Position advance and end test.
  logic [18:0] inc;
  logic [32:0] next_pos;
  logic        voice_end;
  assign inc       = stereo ? {pitch_step, 1'b0} : {1'b0, pitch_step};
  assign next_pos  = {1'b0, pm_q} + 33'(inc);
  assign voice_end = next_pos[32] || ({1'b0, next_pos[31:16]} >= end_position);

  // Sample addresses from the current position.
  logic [31:0]   word_ext;
  logic [AW-1:0] addr_l;
  logic [AW-1:0] addr_r;
  logic [31:0]   load_ext;
  assign word_ext = {16'd0, pm_q[31:16]};
  assign addr_l   = word_ext[AW-1:0];
  assign addr_r   = addr_l + AW'(1);
  assign load_ext = {16'd0, mem_address};

  // Sample memory: one write port, two registered read ports.
  logic smem_we;
  assign smem_we = (state == S_IDLE) && in_valid && (kind == KIND_LOAD);
  always_ff @(posedge clk) begin
    if (smem_we) begin
      smem[load_ext[AW-1:0]] <= mem_value;
    end
    sm_l_q <= smem[addr_l];
    sm_r_q <= smem[addr_r];
  end

  // Position memory: clear sweep or frame write-back, registered read.
  logic          pmem_we;
  logic [TW-1:0] pmem_waddr;
  logic [31:0]   pmem_wdata;
  logic [TW-1:0] pmem_raddr;
  always_comb begin
    pmem_we    = 1'b0;
    pmem_waddr = clr_cnt;
    pmem_wdata = '0;
    if (state == S_CLEAR) begin
      pmem_we = 1'b1;
    end else if (state == S_POS) begin
      pmem_we    = 1'b1;
      pmem_waddr = vtick[vsel];
      pmem_wdata = voice_end ? 32'd0 : next_pos[31:0];
    end
  end
  assign pmem_raddr = vtick[vsel];

  always_ff @(posedge clk) begin
    if (pmem_we) begin
      pmem[pmem_waddr] <= pmem_wdata;
    end
    pm_q <= pmem[pmem_raddr];
  end

  // Per-voice products.
  logic signed [32:0] prod_l;
  logic signed [32:0] prod_r;
  assign prod_l = sm_l_q * $signed({1'b0, gain_q});
  assign prod_r = sm_r_q * $signed({1'b0, gain_q});

  // Volume scaling: combine partial products, round, saturate.
  function automatic logic signed [OUT_W-1:0] scale_out(
    input logic signed [HP_W-1:0] hi,
    input logic [31:0]            lo
  );
    logic signed [FW-1:0]   full;
    logic signed [SH_W-1:0] sh;
    full = ($signed({{(FW - HP_W - 16){hi[HP_W-1]}}, hi, 16'd0}))
           + $signed(FW'(lo)) + $signed(FW'(32'd536870912));
    sh   = SH_W'(full >>> 30);
    if (sh > $signed(SH_W'(524287))) begin
      return OUT_W'(524287);
    end else if (sh < -$signed(SH_W'(524288))) begin
      return OUT_W'(-524288);
    end
    return sh[OUT_W-1:0];
  endfunction

  logic signed [OUT_W-1:0] left_next;
  logic signed [OUT_W-1:0] right_next;
  assign left_next  = scale_out(hi_l, lo_l);
  assign right_next = stereo ? scale_out(hi_r, lo_r) : left_next;

  // Sequencer, voice state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      running      <= 1'b1;
      armed        <= 1'b0;
      out_valid    <= 1'b0;
      vidx         <= '0;
      stereo       <= 1'b0;
      pitch_step   <= PITCH_RESET;
      end_position <= END_RESET;
      volume       <= VOLUME_RESET;
      for (int i = 0; i < VOICES; i++) begin
        busy[i]  <= 1'b0;
        vtick[i] <= '0;
        vvel[i]  <= '0;
      end
    end else begin
      // Configuration writes.
      if (cfg_write) begin
        unique case (cfg_index)
          REG_STEREO: stereo       <= cfg_data[0];
          REG_PITCH:  pitch_step   <= cfg_data;
          REG_END:    end_position <= cfg_data[16:0];
          REG_VOLUME: volume       <= cfg_data[15:0];
          default: ;
        endcase
      end

      // The output step reloads the register itself when it is taken.
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          if (clr_cnt == TW'(TICKS_PER_BAR - 1)) begin
            clr_cnt <= '0;
            state   <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + TW'(1);
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            case (kind)
              KIND_LOOP: begin
                if (running) begin
                  armed <= 1'b1;
                end
              end
              KIND_TICK: begin
                if (running && armed && hit) begin
                  tick_reg <= tick_index;
                  vel_reg  <= velocity;
                  state    <= S_TMOD;
                end
              end
              KIND_FRAME: begin
                vidx  <= '0;
                lsum  <= '0;
                rsum  <= '0;
                state <= S_CHECK;
              end
              KIND_START: begin
                if (!running) begin
                  running <= 1'b1;
                  clr_cnt <= '0;
                  state   <= S_CLEAR;
                  for (int i = 0; i < VOICES; i++) begin
                    busy[i]  <= 1'b0;
                    vtick[i] <= '0;
                    vvel[i]  <= '0;
                  end
                end
              end
              KIND_STOP: running <= 1'b0;
              default: ;
            endcase
          end
        end

        // Wrap the tick index into the bar, then take the lowest free voice.
        S_TMOD: begin
          if ({1'b0, tick_reg} >= 13'(TICKS_PER_BAR)) begin
            tick_reg <= tick_reg - 12'(TICKS_PER_BAR);
          end else begin
            if (free_found) begin
              busy[free_idx]  <= 1'b1;
              vtick[free_idx] <= tick_reg[TW-1:0];
              vvel[free_idx]  <= vel_reg;
            end
            state <= S_IDLE;
          end
        end

        // Skip free voices; a busy one starts its position read.
        S_CHECK: begin
          if (vidx == VCW'(VOICES)) begin
            state <= S_SC1;
          end else if (busy[vsel]) begin
            gain_q <= velocity_gain(vvel[vsel]);
            state  <= S_POS;
          end else begin
            vidx <= vidx + VCW'(1);
          end
        end

        // Position is here: sample reads go out, position is written back.
        S_POS: begin
          if (voice_end) begin
            busy[vsel] <= 1'b0;
          end
          state <= S_MAC;
        end

        S_MAC: begin
          lsum <= lsum + SUM_W'(prod_l);
          if (stereo) begin
            rsum <= rsum + SUM_W'(prod_r);
          end
          vidx  <= vidx + VCW'(1);
          state <= S_CHECK;
        end

        // Low halves of the sums times volume.
        S_SC1: begin
          lo_l  <= lsum[15:0] * volume;
          lo_r  <= rsum[15:0] * volume;
          state <= S_SC2;
        end

        // High halves of the sums times volume.
        S_SC2: begin
          hi_l  <= $signed(lsum[SUM_W-1:16]) * $signed({1'b0, volume});
          hi_r  <= $signed(rsum[SUM_W-1:16]) * $signed({1'b0, volume});
          state <= S_OUT;
        end

        S_OUT: begin
          if (!out_valid || !out_stall) begin
            left_out  <= left_next;
            right_out <= right_next;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // A frame item always starts the voice walk from the first voice.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && kind == KIND_FRAME)
      |=> (state == S_CHECK && vidx == '0))
    else $error("frame did not start the voice walk");

  // A finished mix never overwrites a result that is still stalled.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && out_stall) |=> (state == S_OUT))
    else $error("result overwritten while stalled");

  // A voice being mixed is busy and points into the bar.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_POS) |-> (busy[vsel] && (32'(vtick[vsel]) < 32'(TICKS_PER_BAR))))
    else $error("mixing a free voice or a tick outside the bar");

endmodule
